@@ src/gis_pkg.sv @@
package gis_pkg;

	localparam int SIGMOID_POINTS_DEF = 256;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_INDEX_W = 3;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PEAK_COND = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_ACT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOPE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_RISE = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DECAY = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_REVERSAL = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_GATE = 3'd7;

	localparam int DIV_STEPS = 33;
	localparam longint unsigned ONE_Q31 = 64'd1 << 31;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_MP, S_KF, S_PROD, S_INTERP, S_CLO, S_CHI,
		S_RS, S_A, S_DIFF, S_INCLO, S_INCHI, S_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_DIV, OP_MP, OP_KF, OP_PROD, OP_INTERP, OP_CLO,
		OP_CHI, OP_RS, OP_A, OP_DIFF, OP_INCLO, OP_INCHI, OP_FIN
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	// unsigned quotient by shift and subtract, for table building only
	function automatic longint unsigned udiv_q(longint unsigned a, longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// unsigned remainder by shift and subtract, for table building only
	function automatic longint unsigned udiv_r(longint unsigned a, longint unsigned b);
		longint unsigned r;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) r = r - b;
		end
		return r;
	endfunction

	// exp(-num/den) in Q.31 by a truncated Taylor series
	function automatic longint unsigned exp_neg_frac(longint unsigned num,
			longint unsigned den);
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned term;
		pos = ONE_Q31;
		neg = 0;
		term = ONE_Q31;
		for (longint unsigned n = 1; n <= 24; n++) begin
			term = udiv_q(term * num, den * n);
			if (n[0]) neg = neg + term;
			else pos = pos + term;
		end
		return (neg > pos) ? 64'd0 : pos - neg;
	endfunction

	// sigmoid sample k of n over [-8, 8], Q0.16, capped
	function automatic longint unsigned sig_point(longint unsigned k, longint unsigned n);
		longint unsigned a;
		longint unsigned b;
		longint unsigned m;
		longint unsigned ip;
		longint unsigned fp;
		longint unsigned e;
		longint unsigned e1;
		longint unsigned den;
		longint unsigned s;
		logic below;
		a = 16 * k;
		b = 8 * n;
		below = a < b;
		m = below ? b - a : a - b;
		ip = udiv_q(m, n);
		fp = udiv_r(m, n);
		e = exp_neg_frac(fp, n);
		e1 = exp_neg_frac(1, 1);
		for (longint unsigned j = 0; j < ip && j < 16; j++) e = (e * e1) >> 31;
		den = ONE_Q31 + e;
		if (below) s = udiv_q((e << 16) + (den >> 1), den);
		else s = udiv_q((64'd1 << 47) + (den >> 1), den);
		return (s > 65535) ? 64'd65535 : s;
	endfunction

endpackage

@@ src/graded_inhibitory_synapse_step.sv @@
// Graded inhibitory synapse, one forward-Euler step per transfer.
// Input channel: in_valid/in_ready with pre_voltage and post_voltage (Q8.8 mV).
// Output channel: out_valid/out_ready with synaptic_current, gate_value and
// saturated; exactly one result per input transfer, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while no step is in flight. Writing initial_gate reloads the gate.
// One item at a time: the sequencer takes no new input until the last step of the
// current one. Each item passes the 33-step bit-serial divider for the sigmoid
// argument and then the shared 32x17 multiplier, used ten times in turn.
// in_ready is high only while the sequencer is idle.
// A finished result waits in the output register; the next item is accepted
// and computed meanwhile, and holds in its last step until that result is
// taken if the receiver stalls.
// Reset clears the sequencer and the output valid, loads the register
// defaults and sets the gate to zero.
module graded_inhibitory_synapse_step #(
	parameter int SIGMOID_POINTS = gis_pkg::SIGMOID_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                pre_voltage,
	input  logic signed [15:0]                post_voltage,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                synaptic_current,
	output logic [15:0]                       gate_value,
	output logic                              saturated,
	input  logic                              cfg_we,
	input  logic [gis_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [gis_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import gis_pkg::*;

	cmd_t cmd;
	status_t stat;

	gis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gis_datapath #(
		.SIGMOID_POINTS (SIGMOID_POINTS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.pre_voltage      (pre_voltage),
		.post_voltage     (post_voltage),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.synaptic_current (synaptic_current),
		.gate_value       (gate_value),
		.saturated        (saturated)
	);
endmodule

@@ src/gis_ctrl.sv @@
module gis_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gis_pkg::status_t  stat,
	output gis_pkg::cmd_t     cmd
);
	import gis_pkg::*;

	state_t state_q;
	state_t state_n;
	logic [5:0] cnt_q;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_n = S_DIV;
			S_DIV: if (cnt_q == 6'(DIV_STEPS - 1)) state_n = S_MP;
			S_MP: state_n = S_KF;
			S_KF: state_n = S_PROD;
			S_PROD: state_n = S_INTERP;
			S_INTERP: state_n = S_CLO;
			S_CLO: state_n = S_CHI;
			S_CHI: state_n = S_RS;
			S_RS: state_n = S_A;
			S_A: state_n = S_DIFF;
			S_DIFF: state_n = S_INCLO;
			S_INCLO: state_n = S_INCHI;
			S_INCHI: state_n = S_FIN;
			S_FIN: if (stat.out_free) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_DIV: cmd.op = OP_DIV;
			S_MP: cmd.op = OP_MP;
			S_KF: cmd.op = OP_KF;
			S_PROD: cmd.op = OP_PROD;
			S_INTERP: cmd.op = OP_INTERP;
			S_CLO: cmd.op = OP_CLO;
			S_CHI: cmd.op = OP_CHI;
			S_RS: cmd.op = OP_RS;
			S_A: cmd.op = OP_A;
			S_DIFF: cmd.op = OP_DIFF;
			S_INCLO: cmd.op = OP_INCLO;
			S_INCHI: cmd.op = OP_INCHI;
			S_FIN: if (stat.out_free) cmd.op = OP_FIN;
			default: cmd.op = OP_NONE;
		endcase
	end

	// state and divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == S_DIV) cnt_q <= cnt_q + 6'd1;
			else cnt_q <= '0;
		end
	end
endmodule

@@ src/gis_datapath.sv @@
module gis_datapath #(
	parameter int SIGMOID_POINTS = gis_pkg::SIGMOID_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gis_pkg::cmd_t                     cmd,
	output gis_pkg::status_t                  stat,
	input  logic signed [15:0]                pre_voltage,
	input  logic signed [15:0]                post_voltage,
	input  logic                              cfg_we,
	input  logic [gis_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [gis_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                synaptic_current,
	output logic [15:0]                       gate_value,
	output logic                              saturated
);
	import gis_pkg::*;

	localparam int KW = $clog2(SIGMOID_POINTS + 1);
	localparam logic [KW-1:0] K_LAST = KW'(SIGMOID_POINTS);

	typedef logic [15:0] sig_tbl_t [0:SIGMOID_POINTS];

	function automatic sig_tbl_t build_tbl();
		sig_tbl_t t;
		for (int i = 0; i <= SIGMOID_POINTS; i++)
			t[i] = 16'(sig_point(longint'(i), longint'(SIGMOID_POINTS)));
		return t;
	endfunction

	localparam sig_tbl_t SIG_TBL = build_tbl();

	// configuration
	logic [15:0] time_step_q;
	logic [23:0] peak_cond_q;
	logic signed [15:0] half_act_q;
	logic [14:0] slope_q;
	logic [15:0] rise_q;
	logic [15:0] decay_q;
	logic signed [15:0] reversal_q;
	logic [15:0] gate_q;

	// working registers
	logic aneg_q;
	logic [16:0] bmag_q;
	logic bneg_q;
	logic [14:0] rem_q;
	logic [32:0] dvd_q;
	logic [48:0] m_q;
	logic [19:0] f_q;
	logic [15:0] t0_q;
	logic [15:0] t1_q;
	logic [39:0] prod_q;
	logic [15:0] s_q;
	logic [37:0] lo_q;
	logic [31:0] cur_q;
	logic csat_q;
	logic [48:0] a_q;
	logic [48:0] dmag_q;
	logic dneg_q;
	logic [40:0] lo2_q;

	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic signed [16:0] dva;
	logic signed [16:0] dvb;
	logic [14:0] sig_eff;
	logic [15:0] rem_n;
	logic rem_ge;
	logic [19:0] xmag;
	logic [20:0] p_c;
	logic [KW-1:0] k_c;
	logic [KW-1:0] idx0;
	logic [KW-1:0] idx1;
	logic [15:0] tdiff;
	logic [15:0] tstep;
	logic [34:0] cmag;
	logic signed [49:0] diff_c;
	logic [41:0] inc_sum;
	logic [25:0] inc_c;
	logic signed [27:0] newg_c;
	logic [15:0] newg_sat;
	logic gsat;

	assign stat.out_free = !out_valid || out_ready;
	assign dva = 17'(pre_voltage) - 17'(half_act_q);
	assign dvb = 17'(post_voltage) - 17'(reversal_q);
	assign sig_eff = (slope_q == '0) ? 15'd1 : slope_q;

	// restoring divider step
	assign rem_n = {rem_q, dvd_q[32]};
	assign rem_ge = rem_n >= {1'b0, sig_eff};

	// sigmoid argument clamp and table address
	assign xmag = (dvd_q > 33'd524288) ? 20'd524288 : dvd_q[19:0];
	assign p_c = aneg_q ? 21'd524288 - 21'(xmag) : 21'd524288 + 21'(xmag);
	assign k_c = m_q[20 +: KW];
	assign idx0 = (k_c >= K_LAST) ? K_LAST : k_c;
	assign idx1 = (k_c >= K_LAST) ? K_LAST : k_c + KW'(1);
	assign tdiff = (t1_q >= t0_q) ? t1_q - t0_q : t0_q - t1_q;
	assign tstep = m_q[35:20];

	// current magnitude and gate update
	assign cmag = 35'((39'(m_q[37:0]) + 39'(lo_q >> 20)) >> 4);
	assign diff_c = $signed({1'b0, a_q}) - $signed({2'b00, m_q[31:0], 16'h0000});
	assign inc_sum = 42'(m_q[40:0]) + 42'(lo2_q >> 24);
	assign inc_c = inc_sum[41:16];
	assign newg_c = dneg_q ? $signed({12'h000, gate_q}) - $signed({2'b00, inc_c})
		: $signed({12'h000, gate_q}) + $signed({2'b00, inc_c});
	always_comb begin
		gsat = 1'b0;
		newg_sat = newg_c[15:0];
		if (newg_c < 0) begin
			gsat = 1'b1;
			newg_sat = 16'h0000;
		end else if (newg_c > 28'sd65535) begin
			gsat = 1'b1;
			newg_sat = 16'hFFFF;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MP: begin
				mul_a = 32'(p_c);
				mul_b = 17'(SIGMOID_POINTS);
			end
			OP_KF: begin
				mul_a = 32'(peak_cond_q);
				mul_b = 17'(gate_q);
			end
			OP_PROD: begin
				mul_a = 32'(f_q);
				mul_b = 17'(tdiff);
			end
			OP_INTERP: begin
				mul_a = 32'(prod_q[19:0]);
				mul_b = bmag_q;
			end
			OP_CLO: begin
				mul_a = 32'(prod_q[39:20]);
				mul_b = bmag_q;
			end
			OP_CHI: begin
				mul_a = 32'(rise_q);
				mul_b = 17'(s_q);
			end
			OP_RS: begin
				mul_a = m_q[31:0];
				mul_b = 17'h10000 - 17'(gate_q);
			end
			OP_A: begin
				mul_a = 32'(decay_q);
				mul_b = 17'(gate_q);
			end
			OP_INCLO: begin
				mul_a = 32'(dmag_q[23:0]);
				mul_b = 17'(time_step_q);
			end
			OP_INCHI: begin
				mul_a = 32'(dmag_q[48:24]);
				mul_b = 17'(time_step_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// datapath registers; hold the product while the result waits
	always_ff @(posedge clk) begin
		if (cmd.op != OP_NONE) m_q <= 49'(mul_a) * 49'(mul_b);
		case (cmd.op)
			OP_LOAD: begin
				aneg_q <= dva < 0;
				bneg_q <= dvb > 0;
				bmag_q <= (dvb < 0) ? 17'(-dvb) : 17'(dvb);
				rem_q <= '0;
				dvd_q <= {((dva < 0) ? 17'(-dva) : 17'(dva)), 16'h0000};
			end
			OP_DIV: begin
				rem_q <= rem_ge ? 15'(rem_n - {1'b0, sig_eff}) : rem_n[14:0];
				dvd_q <= {dvd_q[31:0], rem_ge};
			end
			OP_KF: begin
				f_q <= m_q[19:0];
				t0_q <= SIG_TBL[idx0];
				t1_q <= SIG_TBL[idx1];
			end
			OP_PROD: prod_q <= m_q[39:0];
			OP_INTERP: s_q <= (t1_q >= t0_q) ? t0_q + tstep : t0_q - tstep;
			OP_CLO: lo_q <= m_q[37:0] + 38'd8388608;
			OP_CHI: begin
				// clamp to the signed 32-bit range
				if (bneg_q) begin
					csat_q <= cmag > 35'h080000000;
					cur_q <= (cmag > 35'h080000000) ? 32'h80000000 : 32'(-cmag);
				end else begin
					csat_q <= cmag > 35'h07FFFFFFF;
					cur_q <= (cmag > 35'h07FFFFFFF) ? 32'h7FFFFFFF : cmag[31:0];
				end
			end
			OP_A: a_q <= m_q;
			OP_DIFF: begin
				dneg_q <= diff_c < 0;
				dmag_q <= (diff_c < 0) ? 49'(-diff_c) : 49'(diff_c);
			end
			OP_INCHI: lo2_q <= m_q[40:0] + 41'h8000000000;
			OP_FIN: begin
				synaptic_current <= $signed(cur_q);
				gate_value <= newg_sat;
				saturated <= gsat || csat_q;
			end
			default: ;
		endcase
	end

	// configuration, gate state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= 16'd3277;
			peak_cond_q <= '0;
			half_act_q <= '0;
			slope_q <= 15'd256;
			rise_q <= '0;
			decay_q <= '0;
			reversal_q <= '0;
			gate_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TIME_STEP: time_step_q <= cfg_data[15:0];
					REG_PEAK_COND: peak_cond_q <= cfg_data;
					REG_HALF_ACT: half_act_q <= $signed(cfg_data[15:0]);
					REG_SLOPE: slope_q <= cfg_data[14:0];
					REG_RISE: rise_q <= cfg_data[15:0];
					REG_DECAY: decay_q <= cfg_data[15:0];
					REG_REVERSAL: reversal_q <= $signed(cfg_data[15:0]);
					REG_INIT_GATE: gate_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_FIN) begin
				gate_q <= newg_sat;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
